@@ rtl/nvup_pkg.sv @@
// Shared types and constants for the nv12 to 4:4:4 chroma upsampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package nvup_pkg;

  // fixed field widths
  localparam int DATA_W    = 8;
  localparam int OFF_W     = 24;
  localparam int PLANE_W   = 2;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register reset values
  localparam int FRAME_WIDTH_RESET  = 1920;
  localparam int FRAME_HEIGHT_RESET = 1080;

  // destination plane codes
  localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U    = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V    = 2'd2;

  // request info passed from the sequencing stage to the address stage
  typedef struct packed {
    logic              is_chroma;
    logic              done;
    logic [DATA_W-1:0] u;       // luma byte for luma requests
    logic [DATA_W-1:0] v;
  } meta_t;

  // request with its resolved base offset, held by the write emitter
  typedef struct packed {
    logic              is_chroma;
    logic              done;
    logic [DATA_W-1:0] u;
    logic [DATA_W-1:0] v;
    logic [OFF_W-1:0]  base;
  } emit_req_t;

endpackage

@@ rtl/nvup_cfg.sv @@
// Frame size registers: effective even width and height and the luma plane size.
// Depends on nvup_pkg.
`timescale 1ns / 1ps

module nvup_cfg import nvup_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [WW-1:0]        w_eff,
  output logic [HW-1:0]        h_eff,
  output logic [WW+HW-1:0]     px
);

  localparam int PW    = WW + HW;
  localparam int LIM_W = (MAX_WIDTH / 2) * 2;
  localparam int LIM_H = (MAX_HEIGHT / 2) * 2;
  localparam int RST_W = (FRAME_WIDTH_RESET > LIM_W) ? LIM_W : FRAME_WIDTH_RESET;
  localparam int RST_H = (FRAME_HEIGHT_RESET > LIM_H) ? LIM_H : FRAME_HEIGHT_RESET;
  localparam logic [PW-1:0] RST_PX = PW'(RST_W * RST_H);

  logic [WW-1:0] w_eff_next;
  logic [HW-1:0] h_eff_next;
  logic [PW-1:0] px_next;

  // clear the low bit and clamp into 2..limit
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] e;
    e = {v[CFG_W-1:1], 1'b0};
    if (e < CFG_W'(2)) return WW'(2);
    if (32'(e) > LIM_W) return WW'(LIM_W);
    return WW'(e);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] e;
    e = {v[CFG_W-1:1], 1'b0};
    if (e < CFG_W'(2)) return HW'(2);
    if (32'(e) > LIM_H) return HW'(LIM_H);
    return HW'(e);
  endfunction

  // next sizes on a register write
  always_comb begin
    w_eff_next = w_eff;
    h_eff_next = h_eff;
    if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
      w_eff_next = clamp_w(cfg_data);
    end
    if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
      h_eff_next = clamp_h(cfg_data);
    end
    px_next = w_eff_next * h_eff_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WW'(RST_W);
      h_eff <= HW'(RST_H);
      px    <= RST_PX;
    end else if (cfg_we) begin
      w_eff <= w_eff_next;
      h_eff <= h_eff_next;
      px    <= px_next;
    end
  end

endmodule

@@ rtl/nvup_ctl.sv @@
// Stream sequencer: tracks luma and chroma position and issues one request
// per luma byte and per U,V pair. Depends on nvup_pkg.
`timescale 1ns / 1ps

module nvup_ctl import nvup_pkg::*; #(
  parameter int WW = 13,
  parameter int HW = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic [WW-1:0]      w_eff,
  input  logic [HW-1:0]      h_eff,
  input  logic [WW+HW-1:0]   px,
  input  logic               next_ready,
  output logic               req_valid,
  output meta_t              req_meta,
  output logic [WW-1:0]      req_x,
  output logic [HW-1:0]      req_y,
  output logic [OFF_W-1:0]   req_luma_off
);

  localparam int PW = WW + HW;
  localparam int CW = WW - 1;
  localparam int RW = HW - 1;

  logic              in_chroma_part, in_chroma_part_next;
  logic              u_pending, u_pending_next;
  logic [PW-1:0]     luma_position, luma_position_next;
  logic [CW-1:0]     chroma_column, chroma_column_next;
  logic [RW-1:0]     chroma_row, chroma_row_next;
  logic [DATA_W-1:0] held_u;

  logic          ready;
  logic          accept;
  logic          produce;
  logic          done;
  logic [PW-1:0] pos_c, pos_inc;
  logic [CW-1:0] hw, col_c, col_inc;
  logic [RW-1:0] hh, row_c, row_inc;

  assign ready      = !req_valid || next_ready;
  assign byte_stall = !ready;
  assign accept     = byte_valid && ready;
  assign produce    = accept && (!in_chroma_part || u_pending);

  // positions clamped to the current frame size
  assign hw      = w_eff[WW-1:1];
  assign hh      = h_eff[HW-1:1];
  assign pos_c   = (luma_position >= px) ? px - PW'(1) : luma_position;
  assign pos_inc = pos_c + PW'(1);
  assign col_c   = (chroma_column >= hw) ? hw - CW'(1) : chroma_column;
  assign col_inc = col_c + CW'(1);
  assign row_c   = (chroma_row >= hh) ? hh - RW'(1) : chroma_row;
  assign row_inc = row_c + RW'(1);

  // next position state
  always_comb begin
    in_chroma_part_next = in_chroma_part;
    u_pending_next      = u_pending;
    luma_position_next  = luma_position;
    chroma_column_next  = chroma_column;
    chroma_row_next     = chroma_row;
    done                = 1'b0;
    if (accept) begin
      if (!in_chroma_part) begin
        if (pos_inc >= px) begin
          luma_position_next  = '0;
          in_chroma_part_next = 1'b1;
          chroma_column_next  = '0;
          chroma_row_next     = '0;
          u_pending_next      = 1'b0;
        end else begin
          luma_position_next = pos_inc;
        end
      end else if (!u_pending) begin
        u_pending_next = 1'b1;
      end else begin
        u_pending_next = 1'b0;
        if (col_inc >= hw) begin
          chroma_column_next = '0;
          if (row_inc >= hh) begin
            chroma_row_next     = '0;
            done                = 1'b1;
            in_chroma_part_next = 1'b0;
            luma_position_next  = '0;
          end else begin
            chroma_row_next = row_inc;
          end
        end else begin
          chroma_column_next = col_inc;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_chroma_part <= 1'b0;
      u_pending      <= 1'b0;
      luma_position  <= '0;
      chroma_column  <= '0;
      chroma_row     <= '0;
      req_valid      <= 1'b0;
    end else begin
      in_chroma_part <= in_chroma_part_next;
      u_pending      <= u_pending_next;
      luma_position  <= luma_position_next;
      chroma_column  <= chroma_column_next;
      chroma_row     <= chroma_row_next;
      if (ready) begin
        req_valid <= produce;
      end
    end
  end

  // held u byte and request payload
  always_ff @(posedge clk) begin
    if (accept && in_chroma_part && !u_pending) begin
      held_u <= data_byte;
    end
    if (produce) begin
      req_meta.is_chroma <= in_chroma_part;
      req_meta.done      <= done;
      req_meta.u         <= in_chroma_part ? held_u : data_byte;
      req_meta.v         <= data_byte;
      req_x              <= {col_c, 1'b0};
      req_y              <= {row_c, 1'b0};
      req_luma_off       <= OFF_W'(pos_c);
    end
  end

endmodule

@@ rtl/nvup_addr.sv @@
// Address stage: forms the base plane offset of each request, row*width+column
// for chroma blocks. Depends on nvup_pkg.
`timescale 1ns / 1ps

module nvup_addr import nvup_pkg::*; #(
  parameter int WW = 13,
  parameter int HW = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WW-1:0]    w_eff,
  input  logic             req_valid,
  input  meta_t            req_meta,
  input  logic [WW-1:0]    req_x,
  input  logic [HW-1:0]    req_y,
  input  logic [OFF_W-1:0] req_luma_off,
  output logic             ready,
  input  logic             emit_take,
  output logic             emit_valid,
  output emit_req_t        emit_req
);

  localparam int PW = WW + HW;

  logic [PW-1:0]    row_base;
  logic [OFF_W-1:0] base;

  assign ready = !emit_valid || emit_take;

  // block origin offset
  assign row_base = req_y * w_eff;
  assign base     = req_meta.is_chroma ? OFF_W'(row_base + PW'(req_x)) : req_luma_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
    end else if (ready) begin
      emit_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && req_valid) begin
      emit_req.is_chroma <= req_meta.is_chroma;
      emit_req.done      <= req_meta.done;
      emit_req.u         <= req_meta.u;
      emit_req.v         <= req_meta.v;
      emit_req.base      <= base;
    end
  end

endmodule

@@ rtl/nvup_emit.sv @@
// Write emitter: one write per luma request, eight writes per chroma block
// (U then V at each of the four pixels). Depends on nvup_pkg.
`timescale 1ns / 1ps

module nvup_emit import nvup_pkg::*; #(
  parameter int WW = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [WW-1:0]      w_eff,
  input  logic               emit_valid,
  input  emit_req_t          emit_req,
  output logic               emit_take,
  output logic               wr_valid,
  input  logic               wr_stall,
  output logic [PLANE_W-1:0] plane_select,
  output logic [OFF_W-1:0]   plane_offset,
  output logic [DATA_W-1:0]  pixel_value,
  output logic               run_last,
  output logic               frame_done
);

  localparam logic [2:0] LAST_BEAT = 3'd7;

  emit_req_t  req;
  logic [2:0] beat;
  logic       last_beat;
  logic       wr_accept;

  assign last_beat = !req.is_chroma || beat == LAST_BEAT;
  assign wr_accept = wr_valid && !wr_stall;
  assign emit_take = !wr_valid || (wr_accept && last_beat);

  // beat order: pixel (x,y),(x+1,y),(x,y+1),(x+1,y+1), U then V at each
  always_comb begin
    if (req.is_chroma) begin
      plane_select = beat[0] ? PLANE_V : PLANE_U;
      plane_offset = req.base + OFF_W'(beat[1]) + (beat[2] ? OFF_W'(w_eff) : '0);
      pixel_value  = beat[0] ? req.v : req.u;
      run_last     = beat == LAST_BEAT;
      frame_done   = req.done && beat == LAST_BEAT;
    end else begin
      plane_select = PLANE_LUMA;
      plane_offset = req.base;
      pixel_value  = req.u;
      run_last     = 1'b1;
      frame_done   = 1'b0;
    end
  end

  // request and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
      beat     <= '0;
    end else if (emit_take) begin
      wr_valid <= emit_valid;
      beat     <= '0;
    end else if (wr_accept) begin
      beat <= beat + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take && emit_valid) begin
      req <= emit_req;
    end
  end

`ifndef SYNTH
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    wr_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  a_luma_single: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !req.is_chroma |-> beat == 3'd0)
    else $error("luma request past first beat");

  a_block_continues: assert property (@(posedge clk) disable iff (rst)
    wr_accept && !run_last |=> wr_valid)
    else $error("chroma block dropped before last write");

  a_beat_advance: assert property (@(posedge clk) disable iff (rst)
    wr_accept && !run_last |=> beat == $past(beat) + 3'd1)
    else $error("beat counter skipped");
`endif

endmodule

@@ rtl/nv12_chroma_upsample_444.sv @@
// Top level of the nv12 to planar 4:4:4 chroma upsampler.
// Depends on nvup_pkg, nvup_cfg, nvup_ctl, nvup_addr, nvup_emit.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | byte_valid, byte_stall | data_byte
//   output   | wr_valid, wr_stall     | plane_select, plane_offset, pixel_value,
//            |                        | run_last, frame_done
//   config   | cfg_we                 | cfg_index, cfg_data
//
// A luma byte yields one write and a U,V pair eight, all through the single
// write port of the emitter. An accepted byte passes through the request
// registers of nvup_ctl and nvup_addr and the emitter register before it is written.
// rst is synchronous; it returns to the luma phase at offset 0, size 1920x1080.
// wr_stall holds the current write and backs up through the two request
// stages to byte_stall; a U byte produces no write.
`timescale 1ns / 1ps

module nv12_chroma_upsample_444 import nvup_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [DATA_W-1:0]    data_byte,
  output logic                 wr_valid,
  input  logic                 wr_stall,
  output logic [PLANE_W-1:0]   plane_select,
  output logic [OFF_W-1:0]     plane_offset,
  output logic [DATA_W-1:0]    pixel_value,
  output logic                 run_last,
  output logic                 frame_done
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [WW+HW-1:0] px;

  logic             req_valid;
  meta_t            req_meta;
  logic [WW-1:0]    req_x;
  logic [HW-1:0]    req_y;
  logic [OFF_W-1:0] req_luma_off;
  logic             addr_ready;

  logic             emit_valid;
  emit_req_t        emit_req;
  logic             emit_take;

  // frame size registers
  nvup_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .px        (px)
  );

  // stream position tracking
  nvup_ctl #(
    .WW (WW),
    .HW (HW)
  ) u_ctl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .px           (px),
    .next_ready   (addr_ready),
    .req_valid    (req_valid),
    .req_meta     (req_meta),
    .req_x        (req_x),
    .req_y        (req_y),
    .req_luma_off (req_luma_off)
  );

  // base offset
  nvup_addr #(
    .WW (WW),
    .HW (HW)
  ) u_addr (
    .clk          (clk),
    .rst          (rst),
    .w_eff        (w_eff),
    .req_valid    (req_valid),
    .req_meta     (req_meta),
    .req_x        (req_x),
    .req_y        (req_y),
    .req_luma_off (req_luma_off),
    .ready        (addr_ready),
    .emit_take    (emit_take),
    .emit_valid   (emit_valid),
    .emit_req     (emit_req)
  );

  // write sequencing
  nvup_emit #(
    .WW (WW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .w_eff        (w_eff),
    .emit_valid   (emit_valid),
    .emit_req     (emit_req),
    .emit_take    (emit_take),
    .wr_valid     (wr_valid),
    .wr_stall     (wr_stall),
    .plane_select (plane_select),
    .plane_offset (plane_offset),
    .pixel_value  (pixel_value),
    .run_last     (run_last),
    .frame_done   (frame_done)
  );

endmodule
